// ===== rtl/i2cm_pkg.sv =====
// Package with the command codes, line action codes, beat types and sequence tables.
`default_nettype none
package i2cm_pkg;

	localparam int TppW = 16;
	localparam int IdxW = 5;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_SEND  = 3'd3;
	localparam logic [2:0] CMD_RECV  = 3'd4;
	localparam logic [2:0] CMD_SACK  = 3'd5;
	localparam logic [2:0] CMD_RACK  = 3'd6;

	localparam logic [2:0] ACT_SCL0   = 3'd0;
	localparam logic [2:0] ACT_SCL1   = 3'd1;
	localparam logic [2:0] ACT_SDA0   = 3'd2;
	localparam logic [2:0] ACT_SDA1   = 3'd3;
	localparam logic [2:0] ACT_SDABIT = 3'd4;
	localparam logic [2:0] ACT_SAMPLE = 3'd5;

	localparam logic [TppW-1:0] TPP_RESET = 16'd10;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       ack_out;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_in;
		logic       rejected;
	} res_t;

	// Quotient by three for a five-bit value, by multiplying with 11/32.
	function automatic logic [3:0] div3(input logic [IdxW-1:0] v);
		logic [8:0] p;
		p = 9'(v) * 9'd11;
		return p[8:5];
	endfunction

	function automatic logic [IdxW-1:0] mod3(input logic [IdxW-1:0] v);
		logic [3:0] q;
		q = div3(v);
		return v - (5'(q) * 5'd3);
	endfunction

	function automatic logic [IdxW-1:0] seq_len(input logic [2:0] c);
		logic [IdxW-1:0] n;
		case (c)
			CMD_START: n = 5'd4;
			CMD_STOP:  n = 5'd3;
			CMD_SEND:  n = 5'd24;
			CMD_RECV:  n = 5'd25;
			CMD_SACK:  n = 5'd3;
			CMD_RACK:  n = 5'd4;
			default:   n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] act_kind(input logic [2:0] c, input logic [IdxW-1:0] idx);
		logic [2:0]      k;
		logic [IdxW-1:0] m;
		logic [IdxW-1:0] m1;
		m  = mod3(idx);
		m1 = mod3(idx - 5'd1);
		case (c)
			CMD_START: begin
				case (idx[1:0])
					2'd0:    k = ACT_SDA1;
					2'd1:    k = ACT_SCL1;
					2'd2:    k = ACT_SDA0;
					default: k = ACT_SCL0;
				endcase
			end
			CMD_STOP: begin
				if (idx == 5'd0) begin
					k = ACT_SDA0;
				end else if (idx == 5'd1) begin
					k = ACT_SCL1;
				end else begin
					k = ACT_SDA1;
				end
			end
			CMD_SEND: begin
				if (m == 5'd0) begin
					k = ACT_SDABIT;
				end else if (m == 5'd1) begin
					k = ACT_SCL1;
				end else begin
					k = ACT_SCL0;
				end
			end
			CMD_RECV: begin
				if (idx == 5'd0) begin
					k = ACT_SDA1;
				end else if (m1 == 5'd0) begin
					k = ACT_SCL1;
				end else if (m1 == 5'd1) begin
					k = ACT_SAMPLE;
				end else begin
					k = ACT_SCL0;
				end
			end
			CMD_SACK: begin
				if (idx == 5'd0) begin
					k = ACT_SDABIT;
				end else if (idx == 5'd1) begin
					k = ACT_SCL1;
				end else begin
					k = ACT_SCL0;
				end
			end
			default: begin
				case (idx[1:0])
					2'd0:    k = ACT_SDA1;
					2'd1:    k = ACT_SCL1;
					2'd2:    k = ACT_SAMPLE;
					default: k = ACT_SCL0;
				endcase
			end
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/i2cm_in_if.sv =====
// Input channel interface carrying one tick's command and line sample.
`default_nettype none
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] tx_byte;
	logic       ack_out;
	logic       sda_in;

	modport source (output valid, cmd, tx_byte, ack_out, sda_in, input ready);
	modport sink (input valid, cmd, tx_byte, ack_out, sda_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2cm_out_if.sv =====
// Result channel interface carrying line levels and status for one tick.
`default_nettype none
interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_in;
	logic       rejected;

	modport source (output valid, scl, sda_out, busy_res, done_res, rx_byte, ack_in, rejected,
		input ready);
	modport sink (input valid, scl, sda_out, busy_res, done_res, rx_byte, ack_in, rejected,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/i2cm_cfg_if.sv =====
// Configuration write channel interface for the phase length register.
`default_nettype none
interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2cm_core.sv =====
// Sequencer state and the per-tick next-state and result logic.
`default_nettype none
module i2cm_core
	import i2cm_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire item_t           item,
	input  wire logic [TppW-1:0] tpp,
	output res_t                 res
);

	logic [2:0]      cmd_q, cmd_n;
	logic [IdxW-1:0] idx_q, idx_n;
	logic [TppW-1:0] hold_q, hold_n;
	logic [7:0]      shift_q, shift_n;
	logic            scl_q, scl_n;
	logic            sda_q, sda_n;
	logic            ack_q, ack_n;
	logic [7:0]      rx_q, rx_n;

	logic [TppW-1:0] hc_inc;
	logic [TppW-1:0] tpp_eff;
	logic [2:0]      kind;
	logic [2:0]      app_kind;
	logic [3:0]      rx_div;
	logic [3:0]      tx_div;
	logic [2:0]      rx_bit;
	logic [2:0]      tx_bit;
	logic            do_apply;
	logic            done;
	logic            rej;

	always_comb begin
		cmd_n    = cmd_q;
		idx_n    = idx_q;
		hold_n   = hold_q;
		shift_n  = shift_q;
		ack_n    = ack_q;
		rx_n     = rx_q;
		done     = 1'b0;
		rej      = 1'b0;
		do_apply = 1'b0;
		hc_inc   = hold_q + 16'd1;
		tpp_eff  = (tpp == '0) ? 16'd1 : tpp;
		kind     = act_kind(cmd_q, idx_q);
		rx_div   = div3(idx_q - 5'd1);
		rx_bit   = rx_div[2:0];
		if (cmd_q != CMD_NONE) begin
			rej    = (item.cmd != CMD_NONE);
			hold_n = hc_inc;
			if (hc_inc >= tpp_eff) begin
				if (kind == ACT_SAMPLE) begin
					if (cmd_q == CMD_RECV) begin
						if (item.sda_in) begin
							shift_n[3'd7 - rx_bit] = 1'b1;
						end
					end else begin
						ack_n = item.sda_in;
					end
				end
				idx_n  = idx_q + 5'd1;
				hold_n = '0;
				if (idx_n >= seq_len(cmd_q)) begin
					if (cmd_q == CMD_RECV) begin
						rx_n = shift_n;
					end
					done  = 1'b1;
					cmd_n = CMD_NONE;
					idx_n = '0;
				end else begin
					do_apply = 1'b1;
				end
			end
		end else if (item.cmd inside {[CMD_START:CMD_RACK]}) begin
			cmd_n    = item.cmd;
			idx_n    = '0;
			hold_n   = '0;
			do_apply = 1'b1;
			case (item.cmd)
				CMD_SEND: shift_n = item.tx_byte;
				CMD_SACK: shift_n = {7'd0, item.ack_out};
				default:  shift_n = '0;
			endcase
		end

		scl_n    = scl_q;
		sda_n    = sda_q;
		app_kind = act_kind(cmd_n, idx_n);
		tx_div   = div3(idx_n);
		tx_bit   = tx_div[2:0];
		if (do_apply) begin
			case (app_kind)
				ACT_SCL0: scl_n = 1'b0;
				ACT_SCL1: scl_n = 1'b1;
				ACT_SDA0: sda_n = 1'b0;
				ACT_SDA1: sda_n = 1'b1;
				ACT_SDABIT: begin
					if (cmd_n == CMD_SEND) begin
						sda_n = shift_n[3'd7 - tx_bit];
					end else begin
						sda_n = shift_n[0];
					end
				end
				default: ;
			endcase
		end

		res.scl      = scl_n;
		res.sda_out  = sda_n;
		res.busy_res = (cmd_n != CMD_NONE);
		res.done_res = done;
		res.rx_byte  = rx_n;
		res.ack_in   = ack_n;
		res.rejected = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_NONE;
			idx_q   <= '0;
			hold_q  <= '0;
			shift_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b1;
			rx_q    <= '0;
		end else if (step) begin
			cmd_q   <= cmd_n;
			idx_q   <= idx_n;
			hold_q  <= hold_n;
			shift_q <= shift_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
			rx_q    <= rx_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine with input and result registers.
// A tick beat that is accepted is held in the input register, and its result beat then in the result register.
// Throughput: one tick beat per cycle; the result register and the input
// register both advance whenever the result register is empty or being taken.
// Reset: arst_n clears the sequencer to idle with both lines released, the
// phase length to ten ticks, and empties both registers.
`default_nettype none
module i2c_master_bit_engine
	import i2cm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	i2cm_in_if.sink    req,
	i2cm_out_if.source rsp,
	i2cm_cfg_if.sink   cfg
);

	item_t           item_s1;
	logic            valid_s1;
	res_t            res_q;
	logic            rsp_valid_q;
	logic [TppW-1:0] tpp_q;
	res_t            res;
	logic            adv;
	logic            step;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign step      = valid_s1 && adv;
	assign req.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpp_q <= TPP_RESET;
		end else if (cfg.valid) begin
			tpp_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd     <= req.cmd;
			item_s1.tx_byte <= req.tx_byte;
			item_s1.ack_out <= req.ack_out;
			item_s1.sda_in  <= req.sda_in;
		end
		if (step) begin
			res_q <= res;
		end
	end

	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.tpp    (tpp_q),
		.res    (res)
	);

	assign rsp.valid    = rsp_valid_q;
	assign rsp.scl      = res_q.scl;
	assign rsp.sda_out  = res_q.sda_out;
	assign rsp.busy_res = res_q.busy_res;
	assign rsp.done_res = res_q.done_res;
	assign rsp.rx_byte  = res_q.rx_byte;
	assign rsp.ack_in   = res_q.ack_in;
	assign rsp.rejected = res_q.rejected;

endmodule
`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
// Port-level checker for the bit engine and its bind to the top level.
`default_nettype none
module i2cm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic busy_res,
	input wire logic done_res,
	input wire logic rejected
);

	logic busy_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_prev_q <= 1'b0;
		end else if (rsp_valid && rsp_ready) begin
			busy_prev_q <= busy_res;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(busy_res) && $stable(done_res))
	else $error("Result beat dropped or changed while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> !busy_res)
	else $error("Finishing beat still reports busy.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> busy_prev_q)
	else $error("Finishing beat without a command in progress.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rejected |-> busy_prev_q)
	else $error("Command rejected while the sequencer was idle.");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.busy_res  (rsp.busy_res),
	.done_res  (rsp.done_res),
	.rejected  (rsp.rejected)
);
`default_nettype wire

// ===== tb/i2cm_checker.sv =====
// Checker that predicts every result beat of the I2C master bit engine and compares it.
module tb_checker
	import i2cm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	i2cm_in_if   req,
	i2cm_out_if  rsp,
	i2cm_cfg_if  cfg,
	output int   fails,
	output int   pending
);

	logic [15:0] phase_ticks;
	logic [2:0]  active_op;
	logic [4:0]  act_idx;
	logic [15:0] held;
	logic [7:0]  shift_q;
	logic        scl_q;
	logic        sda_q;
	logic        ack_q;
	logic [7:0]  rx_q;
	res_t        line_beats[$];
	int          errs = 0;
	int          waiting = 0;

	assign fails   = errs;
	assign pending = waiting;

	function automatic logic [4:0] actions_of(input logic [2:0] c);
		logic [4:0] n;
		case (c)
			CMD_START, CMD_RACK: n = 5'd4;
			CMD_STOP, CMD_SACK:  n = 5'd3;
			CMD_SEND:            n = 5'd24;
			CMD_RECV:            n = 5'd25;
			default:             n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] action_at(input logic [2:0] c, input logic [4:0] idx);
		logic [2:0] k;
		int         i;
		i = int'(idx);
		case (c)
			CMD_START: begin
				case (i % 4)
					0:       k = ACT_SDA1;
					1:       k = ACT_SCL1;
					2:       k = ACT_SDA0;
					default: k = ACT_SCL0;
				endcase
			end
			CMD_STOP: begin
				k = (i == 0) ? ACT_SDA0 : ((i == 1) ? ACT_SCL1 : ACT_SDA1);
			end
			CMD_SEND: begin
				k = (i % 3 == 0) ? ACT_SDABIT : ((i % 3 == 1) ? ACT_SCL1 : ACT_SCL0);
			end
			CMD_RECV: begin
				if (i == 0) begin
					k = ACT_SDA1;
				end else begin
					k = ((i - 1) % 3 == 0) ? ACT_SCL1 :
						(((i - 1) % 3 == 1) ? ACT_SAMPLE : ACT_SCL0);
				end
			end
			CMD_SACK: begin
				k = (i == 0) ? ACT_SDABIT : ((i == 1) ? ACT_SCL1 : ACT_SCL0);
			end
			default: begin
				case (i % 4)
					0:       k = ACT_SDA1;
					1:       k = ACT_SCL1;
					2:       k = ACT_SAMPLE;
					default: k = ACT_SCL0;
				endcase
			end
		endcase
		return k;
	endfunction

	function automatic void apply_action();
		int bitpos;
		bitpos = 7 - ((int'(act_idx) / 3) % 8);
		case (action_at(active_op, act_idx))
			ACT_SCL0:   scl_q = 1'b0;
			ACT_SCL1:   scl_q = 1'b1;
			ACT_SDA0:   sda_q = 1'b0;
			ACT_SDA1:   sda_q = 1'b1;
			ACT_SDABIT: sda_q = (active_op == CMD_SEND) ? shift_q[bitpos] : shift_q[0];
			default:    ;
		endcase
	endfunction

	function automatic res_t predict_tick(input logic [2:0] c, input logic [7:0] tx,
		input logic ackv, input logic sdi);
		res_t        r;
		int unsigned hold_limit;
		int          bitpos;
		logic        finished;
		logic        refused;
		hold_limit = (phase_ticks == 16'd0) ? 1 : int'(phase_ticks);
		finished   = 1'b0;
		refused    = 1'b0;
		if (active_op != CMD_NONE) begin
			if (c != CMD_NONE) begin
				refused = 1'b1;
			end
			held = held + 16'd1;
			if (held >= hold_limit) begin
				if (action_at(active_op, act_idx) == ACT_SAMPLE) begin
					if (active_op == CMD_RECV) begin
						bitpos = 7 - (((int'(act_idx) - 1) / 3) % 8);
						if (sdi) begin
							shift_q[bitpos] = 1'b1;
						end
					end else begin
						ack_q = sdi;
					end
				end
				act_idx = act_idx + 5'd1;
				held    = 16'd0;
				if (act_idx >= actions_of(active_op)) begin
					if (active_op == CMD_RECV) begin
						rx_q = shift_q;
					end
					finished  = 1'b1;
					active_op = CMD_NONE;
					act_idx   = 5'd0;
				end else begin
					apply_action();
				end
			end
		end else if (c >= CMD_START && c <= CMD_RACK) begin
			active_op = c;
			act_idx   = 5'd0;
			held      = 16'd0;
			if (c == CMD_SEND) begin
				shift_q = tx;
			end else if (c == CMD_SACK) begin
				shift_q = {7'd0, ackv};
			end else begin
				shift_q = 8'd0;
			end
			apply_action();
		end
		r.scl      = scl_q;
		r.sda_out  = sda_q;
		r.busy_res = (active_op != CMD_NONE);
		r.done_res = finished;
		r.rx_byte  = rx_q;
		r.ack_in   = ack_q;
		r.rejected = refused;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			errs = errs + 1;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			phase_ticks = TPP_RESET;
			active_op   = CMD_NONE;
			act_idx     = 5'd0;
			held        = 16'd0;
			shift_q     = 8'd0;
			scl_q       = 1'b1;
			sda_q       = 1'b1;
			ack_q       = 1'b1;
			rx_q        = 8'd0;
			line_beats.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				phase_ticks = cfg.data;
			end
			if (req.valid && req.ready) begin
				line_beats.push_back(predict_tick(req.cmd, req.tx_byte, req.ack_out, req.sda_in));
			end
			if (rsp.valid && rsp.ready) begin
				if (line_beats.size() == 0) begin
					errs = errs + 1;
					$error("result beat arrived with no expectation waiting");
				end else begin
					want = line_beats.pop_front();
					check_field("scl", 8'(want.scl), 8'(rsp.scl));
					check_field("sda_out", 8'(want.sda_out), 8'(rsp.sda_out));
					check_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
					check_field("rx_byte", want.rx_byte, rsp.rx_byte);
					check_field("ack_in", 8'(want.ack_in), 8'(rsp.ack_in));
					check_field("rejected", 8'(want.rejected), 8'(rsp.rejected));
				end
			end
		end
		waiting = line_beats.size();
	end

endmodule

// ===== tb/tb.sv =====
// Top of the I2C master bit engine testbench: clock, reset, stimulus and verdict.
module tb;
	import i2cm_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fails;
	int   pending;
	int   sent = 0;
	int   rcvd = 0;
	int   cur_tpp = 10;
	bit   idle_on = 1'b1;
	bit   last_busy = 1'b0;

	i2cm_in_if  req ();
	i2cm_out_if rsp ();
	i2cm_cfg_if cfg ();

	i2c_master_bit_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	tb_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20000000;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int stall;
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 4) : 0;
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			last_busy = rsp.busy_res;
			rcvd++;
		end
	end

	function automatic int phase_span(input logic [2:0] c);
		int n;
		case (c)
			CMD_START, CMD_RACK: n = 4;
			CMD_STOP, CMD_SACK:  n = 3;
			CMD_SEND:            n = 24;
			CMD_RECV:            n = 25;
			default:             n = 0;
		endcase
		return n * ((cur_tpp == 0) ? 1 : cur_tpp);
	endfunction

	task automatic send_tick(input logic [2:0] c, input logic [7:0] tx, input logic ackv);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.cmd     <= c;
		req.tx_byte <= tx;
		req.ack_out <= ackv;
		req.sda_in  <= 1'($urandom);
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		forever begin
			do @(posedge clk); while (rcvd != sent);
			if (!last_busy) begin
				break;
			end
			send_tick(CMD_NONE, 8'd0, 1'b0);
			req.valid <= 1'b0;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tpp(input logic [15:0] v);
		settle();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_tpp = int'(v);
	endtask

	// The command is followed by enough ticks to finish it, shifted by slack.
	// A slack of minus one puts the next command on the finishing tick.
	task automatic run_cmd(input logic [2:0] c, input logic [7:0] tx, input logic ackv,
		input int slack, input int noise);
		int n;
		n = phase_span(c) + slack;
		send_tick(c, tx, ackv);
		for (int i = 0; i < n; i++) begin
			if (int'($urandom_range(0, 99)) < noise) begin
				send_tick(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
			end else begin
				send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic random_phase(input int beats);
		int         first;
		int         pick;
		int         slack;
		int         noise;
		logic [2:0] c;
		first = sent;
		while (sent - first < beats) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				c = CMD_NONE;
			end else if (pick == 1) begin
				c = CMD_UNUSED;
			end else begin
				c = 3'($urandom_range(1, 6));
			end
			slack = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 20)) :
				int'($urandom_range(0, 4)) - 1;
			noise = ($urandom_range(0, 3) == 0) ? 10 : 0;
			idle_on = ($urandom_range(0, 4) != 0);
			run_cmd(c, 8'($urandom), 1'($urandom), slack, noise);
		end
	endtask

	initial begin
		req.valid   <= 1'b0;
		req.cmd     <= CMD_NONE;
		req.tx_byte <= 8'd0;
		req.ack_out <= 1'b0;
		req.sda_in  <= 1'b1;
		cfg.valid   <= 1'b0;
		cfg.data    <= 16'd0;
		wait (arst_n);
		@(posedge clk);

		run_cmd(CMD_START, 8'd0, 1'b0, 0, 0);
		run_cmd(CMD_STOP, 8'd0, 1'b0, 2, 0);

		// A zero phase length behaves as one tick per action.
		write_tpp(16'd0);
		run_cmd(CMD_SEND, 8'hFF, 1'b0, 0, 0);
		run_cmd(CMD_SEND, 8'h00, 1'b1, -1, 0);
		run_cmd(CMD_SEND, 8'hA5, 1'b0, 0, 0);
		run_cmd(CMD_RECV, 8'h5A, 1'b0, 0, 0);
		run_cmd(CMD_RECV, 8'h00, 1'b1, 0, 50);
		run_cmd(CMD_SACK, 8'hFF, 1'b0, 0, 0);
		run_cmd(CMD_SACK, 8'h00, 1'b1, 0, 0);
		run_cmd(CMD_RACK, 8'h00, 1'b0, 0, 0);
		run_cmd(CMD_RACK, 8'hFF, 1'b1, 0, 0);
		run_cmd(CMD_UNUSED, 8'hFF, 1'b1, 2, 0);

		write_tpp(16'd1);
		random_phase(350);
		write_tpp(16'd2);
		random_phase(250);
		write_tpp(16'($urandom_range(3, 12)));
		random_phase(300);

		// A longer phase: one stop sequence, refused commands early on and on
		// the finishing tick.
		idle_on = 1'b0;
		write_tpp(16'd40);
		send_tick(CMD_STOP, 8'd0, 1'b0);
		repeat (30) send_tick(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
		repeat (phase_span(CMD_STOP) - 31) send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
		send_tick(CMD_SEND, 8'($urandom), 1'($urandom));
		settle();

		if (fails == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_in_if.sv
rtl/i2cm_out_if.sv
rtl/i2cm_cfg_if.sv
rtl/i2cm_core.sv
rtl/i2c_master_bit_engine.sv
rtl/i2cm_checker.sv
tb/i2cm_checker.sv
tb/tb.sv
